// ===== design/tbcbe_pkg.sv =====
// Shared constants and types for the three-band crushing band-pass equalizer.
// Used by the top level, the coefficient and delay memories' users and the checker.
`default_nettype none

package tbcbe_pkg;

	localparam int BAND_COUNT_DEF   = 3;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF   = 32;

	localparam int DELAY_W         = 40;
	localparam int FRAC            = 28;
	localparam int COEF_SLOTS      = 9;
	localparam int DELAYS_PER_BAND = 4;
	localparam int SLOT_W          = 4;
	localparam int FETCH_LAST      = COEF_SLOTS;
	localparam int WET_ONE         = 32768;
	localparam int WET_W           = 16;
	localparam int PADDR_W         = 3;

	// Coefficient slots within one band.
	localparam int SLOT_A0    = 0;
	localparam int SLOT_B1    = 1;
	localparam int SLOT_B2    = 2;
	localparam int SLOT_C0    = 3;
	localparam int SLOT_D1    = 4;
	localparam int SLOT_D2    = 5;
	localparam int SLOT_LEVEL = 6;
	localparam int SLOT_SCALE = 7;
	localparam int SLOT_RECIP = 8;

	// Register indexes on the configuration port.
	localparam logic REG_WET_MIX    = 1'b0;
	localparam logic REG_CRUSH_MODE = 1'b1;

	// Item kinds carried in tuser.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_POST,
		ST_WBACK,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		SP_LVL,
		SP_A0,
		SP_B1,
		SP_B2,
		SP_SCALE,
		SP_RECIP,
		SP_C0,
		SP_D1,
		SP_D2,
		SP_OUT,
		SP_DRY,
		SP_WET
	} step_t;

endpackage

`default_nettype wire

// ===== design/tbcbe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; holds the coefficient words and the band delay terms.
`default_nettype none

module tbcbe_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 27,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/three_band_crushing_bandpass_eq.sv =====
// Three-band crushing band-pass equalizer: top level with sequencer and shared multiplier.
// Depends on tbcbe_pkg and tbcbe_ram.
//
// Each sample item runs band by band: each band fetches its nine coefficient words and four
// delay terms from the memories, runs 8 multiplies (10 when its quantizer is enabled)
// through one shared multiplier, and writes its delay terms back; two more multiplies do
// the wet/dry mix. A coefficient item with a valid band and slot is written to the
// coefficient memory as it is accepted. Items are taken one at a time; a finished sample
// waits in the output register while the next item is accepted. No clearing pass is
// needed after reset.
`default_nettype none

module three_band_crushing_bandpass_eq #(
	parameter int BAND_COUNT   = tbcbe_pkg::BAND_COUNT_DEF,
	parameter int SAMPLE_WIDTH = tbcbe_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = tbcbe_pkg::COEF_WIDTH_DEF,
	parameter int BAND_W       = (BAND_COUNT > 4) ? 3 : ((BAND_COUNT > 2) ? 2 : 1),
	parameter int IN_TDW       =
		((SAMPLE_WIDTH + BAND_W + tbcbe_pkg::SLOT_W + COEF_WIDTH + 7) / 8) * 8,
	parameter int OUT_TDW      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB-style configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbcbe_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// input items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata from bit 0: sample_in, coef_band, coef_slot, coef_value, zero fill
	input  wire logic [IN_TDW-1:0]             s_tdata,
	// s_tuser: command
	input  wire logic [0:0]                    s_tuser,
	// result items
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata from bit 0: sample_out, zero fill
	output logic      [OUT_TDW-1:0]            m_tdata
);

	localparam int SW      = SAMPLE_WIDTH;
	localparam int CW      = COEF_WIDTH;
	localparam int DW      = tbcbe_pkg::DELAY_W;
	localparam int FR      = tbcbe_pkg::FRAC;
	localparam int AW      = 48;
	localparam int BW      = CW + 1;
	localparam int PW      = AW + BW;
	localparam int PH_W    = AW - 20 + BW;
	localparam int XW      = PW + 2;
	localparam int SCW     = (CW < 32) ? CW : 32;
	localparam int CRUSH_W = 2 * BAND_COUNT;
	localparam int CDEPTH  = BAND_COUNT * tbcbe_pkg::COEF_SLOTS;
	localparam int CAW     = $clog2(CDEPTH);
	localparam int DDEPTH  = BAND_COUNT * tbcbe_pkg::DELAYS_PER_BAND;
	localparam int DAW     = $clog2(DDEPTH);
	localparam int DRY_L   = (FR >= SW - 1) ? FR - (SW - 1) : 0;
	localparam int DRY_R   = (FR >= SW - 1) ? 0 : (SW - 1) - FR;
	localparam int FIN_L   = (SW - 1 >= FR) ? (SW - 1) - FR : 0;
	localparam int FIN_R   = (SW - 1 >= FR) ? 0 : FR - (SW - 1);
	localparam int OFF_BND = SW;
	localparam int OFF_SLT = SW + BAND_W;
	localparam int OFF_VAL = SW + BAND_W + tbcbe_pkg::SLOT_W;

	localparam logic signed [XW-1:0] D_HI = (XW'(1) <<< (DW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] D_LO = -D_HI - XW'(1);
	localparam logic signed [XW-1:0] Y_HI = (XW'(1) <<< (SW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] Y_LO = -Y_HI - XW'(1);

	function automatic logic signed [DW-1:0] sat40(input logic signed [XW-1:0] v);
		if (v > D_HI) begin
			return D_HI[DW-1:0];
		end else if (v < D_LO) begin
			return D_LO[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [tbcbe_pkg::WET_W-1:0] wet_q;
	logic [CRUSH_W-1:0]          crush_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q   <= tbcbe_pkg::WET_W'(tbcbe_pkg::WET_ONE);
			crush_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tbcbe_pkg::REG_WET_MIX:    wet_q   <= pwdata[tbcbe_pkg::WET_W-1:0];
				tbcbe_pkg::REG_CRUSH_MODE: crush_q <= pwdata[CRUSH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tbcbe_pkg::REG_WET_MIX:    prdata = 32'(wet_q);
			tbcbe_pkg::REG_CRUSH_MODE: prdata = 32'(crush_q);
			default:                   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- input fields
	logic signed [SW-1:0]             in_sample;
	logic [BAND_W-1:0]                in_band;
	logic [tbcbe_pkg::SLOT_W-1:0]     in_slot;
	logic [CW-1:0]                    in_value;
	logic                             s_acc;
	logic                             coef_ok;

	assign in_sample = $signed(s_tdata[SW-1:0]);
	assign in_band   = s_tdata[OFF_BND +: BAND_W];
	assign in_slot   = s_tdata[OFF_SLT +: tbcbe_pkg::SLOT_W];
	assign in_value  = s_tdata[OFF_VAL +: CW];
	assign s_acc     = s_tvalid && s_tready;
	assign coef_ok   = ({1'b0, in_band} < (BAND_W + 1)'(BAND_COUNT)) &&
		(in_slot < tbcbe_pkg::SLOT_W'(tbcbe_pkg::COEF_SLOTS));

	// ---------------------------------------------------------------- sequencer state
	tbcbe_pkg::state_t state_q, state_d;
	tbcbe_pkg::step_t  step_q;
	logic [3:0]        k_q;
	logic [BAND_W-1:0] band_q;
	logic              last_band;

	logic signed [SW-1:0] x_q;
	logic [CW-1:0]        cf_q [tbcbe_pkg::COEF_SLOTS];
	logic signed [DW-1:0] dl_q [tbcbe_pkg::DELAYS_PER_BAND];
	logic signed [DW-1:0] t_q;
	logic signed [DW-1:0] u_q;
	logic signed [AW-1:0] ua_q;
	logic signed [AW-1:0] sum_q;
	logic signed [PW-1:0] acc_q;
	logic signed [AW-1:0] mul_a_q;
	logic signed [BW-1:0] mul_b_q;
	logic signed [PH_W-1:0] p_s1;
	logic signed [PW-1:0] prod_q;
	logic signed [SW-1:0] y_q;
	logic [SW-1:0]        out_q;
	logic                 out_valid_q;
	logic                 out_load;
	logic                 vld_s1;
	logic [DDEPTH-1:0]    dvalid_q;

	assign last_band = (band_q == BAND_W'(BAND_COUNT - 1));
	assign out_load  = (state_q == tbcbe_pkg::ST_DONE) && (!out_valid_q || m_tready);

	// ---------------------------------------------------------------- memories
	logic           c_we;
	logic [CAW-1:0] c_waddr, c_raddr;
	logic [CW-1:0]  c_rdata;
	logic           d_we;
	logic [DAW-1:0] d_waddr, d_raddr;
	logic [DW-1:0]  d_wdata, d_rdata;

	tbcbe_ram #(.WIDTH(CW), .DEPTH(CDEPTH), .ADDR_W(CAW)) u_coef_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (in_value),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	tbcbe_ram #(.WIDTH(DW), .DEPTH(DDEPTH), .ADDR_W(DAW)) u_delay_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbcbe_pkg::ST_IDLE: begin
				if (s_acc && (s_tuser[0] == tbcbe_pkg::CMD_SAMPLE)) begin
					state_d = tbcbe_pkg::ST_FETCH;
				end
			end
			tbcbe_pkg::ST_FETCH: begin
				if (k_q == 4'(tbcbe_pkg::FETCH_LAST)) begin
					state_d = tbcbe_pkg::ST_MUL_HI;
				end
			end
			tbcbe_pkg::ST_MUL_HI: state_d = tbcbe_pkg::ST_MUL_LO;
			tbcbe_pkg::ST_MUL_LO: state_d = tbcbe_pkg::ST_POST;
			tbcbe_pkg::ST_POST: begin
				priority if (step_q == tbcbe_pkg::SP_OUT) begin
					state_d = tbcbe_pkg::ST_WBACK;
				end else if (step_q == tbcbe_pkg::SP_WET) begin
					state_d = tbcbe_pkg::ST_DONE;
				end else begin
					state_d = tbcbe_pkg::ST_MUL_HI;
				end
			end
			tbcbe_pkg::ST_WBACK: begin
				if (k_q == 4'(tbcbe_pkg::DELAYS_PER_BAND - 1)) begin
					state_d = last_band ? tbcbe_pkg::ST_MUL_HI : tbcbe_pkg::ST_FETCH;
				end
			end
			tbcbe_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = tbcbe_pkg::ST_IDLE;
				end
			end
			default: state_d = tbcbe_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs of the sequencer
	always_comb begin
		s_tready = (state_q == tbcbe_pkg::ST_IDLE);
		c_we     = s_acc && (s_tuser[0] == tbcbe_pkg::CMD_COEF) && coef_ok;
		c_waddr  = CAW'(int'(in_band) * tbcbe_pkg::COEF_SLOTS + int'(in_slot));
		c_raddr  = '0;
		if (k_q < 4'(tbcbe_pkg::COEF_SLOTS)) begin
			c_raddr = CAW'(int'(band_q) * tbcbe_pkg::COEF_SLOTS + int'(k_q));
		end
		d_raddr  = DAW'(int'(band_q) * tbcbe_pkg::DELAYS_PER_BAND + int'(k_q[1:0]));
		d_waddr  = d_raddr;
		d_wdata  = dl_q[k_q[1:0]];
		d_we     = (state_q == tbcbe_pkg::ST_WBACK);
		m_tvalid = out_valid_q;
		m_tdata  = OUT_TDW'(out_q);
	end

	// ---------------------------------------------------------------- datapath helpers
	logic signed [AW-21:0]  mul_ah;
	logic [19:0]            mul_al;
	logic signed [BW+20:0]  mul_lo;
	logic signed [PW-1:0]   r;
	logic signed [XW-1:0]   rx;
	logic signed [CW-1:0]   recip;
	logic signed [BW-1:0]   lvl_x, alvl;
	logic [CRUSH_W-1:0]     cr_sh;
	logic [tbcbe_pkg::WET_W-1:0] wet_c;
	logic [16:0]            dry_w;
	logic signed [XW-1:0]   dry_x;
	logic signed [XW-1:0]   n_x;
	logic signed [DW-1:0]   m_v;
	logic signed [XW-1:0]   y_x;

	assign mul_ah = mul_a_q[AW-1:20];
	assign mul_al = mul_a_q[19:0];
	assign mul_lo = $signed({1'b0, mul_al}) * mul_b_q;

	always_comb begin
		unique case (step_q)
			tbcbe_pkg::SP_LVL:   r = prod_q >>> (SW - 1);
			tbcbe_pkg::SP_SCALE: r = prod_q >>> 15;
			tbcbe_pkg::SP_RECIP,
			tbcbe_pkg::SP_DRY,
			tbcbe_pkg::SP_WET:   r = prod_q;
			default:             r = prod_q >>> FR;
		endcase
	end

	assign rx    = XW'(r);
	assign recip = $signed(cf_q[tbcbe_pkg::SLOT_RECIP]);
	assign lvl_x = BW'($signed(cf_q[tbcbe_pkg::SLOT_LEVEL]));
	assign alvl  = lvl_x[BW-1] ? -lvl_x : lvl_x;
	assign cr_sh = crush_q >> band_q;
	assign wet_c = (wet_q > tbcbe_pkg::WET_W'(tbcbe_pkg::WET_ONE)) ?
		tbcbe_pkg::WET_W'(tbcbe_pkg::WET_ONE) : wet_q;
	assign dry_w = 17'(tbcbe_pkg::WET_ONE) - {1'b0, wet_c};
	assign dry_x = (XW'(x_q) <<< DRY_L) >>> DRY_R;
	// The half-step bias only applies while the band's quantizer is on.
	assign n_x   = (rx + (cr_sh[BAND_COUNT] ? XW'(recip >>> 1) : XW'(0))) >>> FR;
	assign m_v   = sat40((XW'(acc_q) + XW'(prod_q)) >>> 15);
	assign y_x   = (XW'(m_v) <<< FIN_L) >>> FIN_R;

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbcbe_pkg::ST_IDLE;
			step_q      <= tbcbe_pkg::SP_LVL;
			k_q         <= '0;
			band_q      <= '0;
			out_valid_q <= 1'b0;
			dvalid_q    <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				tbcbe_pkg::ST_IDLE: begin
					k_q    <= '0;
					band_q <= '0;
				end
				tbcbe_pkg::ST_FETCH: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'(tbcbe_pkg::FETCH_LAST)) begin
						step_q <= tbcbe_pkg::SP_LVL;
					end
				end
				tbcbe_pkg::ST_POST: begin
					k_q <= '0;
					unique case (step_q)
						tbcbe_pkg::SP_LVL:   step_q <= tbcbe_pkg::SP_A0;
						tbcbe_pkg::SP_A0:    step_q <= tbcbe_pkg::SP_B1;
						tbcbe_pkg::SP_B1:    step_q <= tbcbe_pkg::SP_B2;
						tbcbe_pkg::SP_B2:    step_q <= cr_sh[0] ? tbcbe_pkg::SP_SCALE :
							tbcbe_pkg::SP_C0;
						tbcbe_pkg::SP_SCALE: step_q <= tbcbe_pkg::SP_RECIP;
						tbcbe_pkg::SP_RECIP: step_q <= tbcbe_pkg::SP_C0;
						tbcbe_pkg::SP_C0:    step_q <= tbcbe_pkg::SP_D1;
						tbcbe_pkg::SP_D1:    step_q <= tbcbe_pkg::SP_D2;
						tbcbe_pkg::SP_D2:    step_q <= tbcbe_pkg::SP_OUT;
						tbcbe_pkg::SP_DRY:   step_q <= tbcbe_pkg::SP_WET;
						default:             step_q <= step_q;
					endcase
				end
				tbcbe_pkg::ST_WBACK: begin
					dvalid_q[d_waddr] <= 1'b1;
					k_q <= k_q + 4'd1;
					if (k_q == 4'(tbcbe_pkg::DELAYS_PER_BAND - 1)) begin
						k_q <= '0;
						if (last_band) begin
							step_q <= tbcbe_pkg::SP_DRY;
						end else begin
							band_q <= band_q + BAND_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		vld_s1 <= dvalid_q[d_raddr];
		p_s1   <= mul_ah * mul_b_q;
		prod_q <= $signed({p_s1, 20'b0}) + PW'(mul_lo);
		if (out_load) begin
			out_q <= y_q;
		end
		unique case (state_q)
			tbcbe_pkg::ST_IDLE: begin
				x_q   <= in_sample;
				sum_q <= '0;
			end
			tbcbe_pkg::ST_FETCH: begin
				if (k_q != 4'd0) begin
					cf_q[k_q - 4'd1] <= c_rdata;
					if (k_q <= 4'(tbcbe_pkg::DELAYS_PER_BAND)) begin
						dl_q[2'(k_q - 4'd1)] <= vld_s1 ? $signed(d_rdata) : '0;
					end
				end
				mul_a_q <= AW'(x_q);
				mul_b_q <= alvl;
			end
			tbcbe_pkg::ST_POST: begin
				unique case (step_q)
					tbcbe_pkg::SP_LVL: begin
						u_q     <= sat40(rx);
						mul_a_q <= AW'(sat40(rx));
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_A0]));
					end
					tbcbe_pkg::SP_A0: begin
						ua_q    <= AW'(r);
						t_q     <= sat40(rx + XW'(dl_q[0]));
						mul_a_q <= AW'(sat40(rx + XW'(dl_q[0])));
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_B1]));
					end
					tbcbe_pkg::SP_B1: begin
						dl_q[0] <= sat40(XW'(dl_q[1]) - rx);
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_B2]));
					end
					tbcbe_pkg::SP_B2: begin
						dl_q[1] <= sat40(-XW'(ua_q) - rx);
						mul_a_q <= AW'(t_q);
						mul_b_q <= cr_sh[0] ? BW'(cf_q[tbcbe_pkg::SLOT_SCALE][SCW-1:0]) :
							BW'($signed(cf_q[tbcbe_pkg::SLOT_C0]));
					end
					tbcbe_pkg::SP_SCALE: begin
						mul_a_q <= AW'(n_x);
						mul_b_q <= BW'(recip);
					end
					tbcbe_pkg::SP_RECIP: begin
						t_q     <= sat40(rx);
						mul_a_q <= AW'(sat40(rx));
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_C0]));
					end
					tbcbe_pkg::SP_C0: begin
						ua_q    <= AW'(r);
						u_q     <= sat40(rx + XW'(dl_q[2]));
						mul_a_q <= AW'(sat40(rx + XW'(dl_q[2])));
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_D1]));
					end
					tbcbe_pkg::SP_D1: begin
						dl_q[2] <= sat40(XW'(dl_q[3]) - rx);
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_D2]));
					end
					tbcbe_pkg::SP_D2: begin
						dl_q[3] <= sat40(-XW'(ua_q) - rx);
						mul_a_q <= AW'(u_q);
						mul_b_q <= BW'($signed(cf_q[tbcbe_pkg::SLOT_LEVEL]));
					end
					tbcbe_pkg::SP_OUT: begin
						sum_q <= sum_q + AW'(sat40(rx));
					end
					tbcbe_pkg::SP_DRY: begin
						acc_q   <= prod_q;
						mul_a_q <= sum_q;
						mul_b_q <= BW'({1'b0, wet_c});
					end
					tbcbe_pkg::SP_WET: begin
						if (y_x > Y_HI) begin
							y_q <= Y_HI[SW-1:0];
						end else if (y_x < Y_LO) begin
							y_q <= Y_LO[SW-1:0];
						end else begin
							y_q <= y_x[SW-1:0];
						end
					end
					default: ;
				endcase
			end
			tbcbe_pkg::ST_WBACK: begin
				mul_a_q <= AW'(dry_x);
				mul_b_q <= BW'(dry_w);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/tbcbe_chk.sv =====
// Port-level checker for the equalizer top level, attached by the bind below.
// Depends on tbcbe_pkg for the default output width and the item kinds.
`default_nettype none

module tbcbe_chk #(
	parameter int OUT_TDW = ((tbcbe_pkg::SAMPLE_WIDTH_DEF + 7) / 8) * 8
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic [0:0]         s_tuser,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [OUT_TDW-1:0] m_tdata
);

	// A stalled result item stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item withdrawn while stalled");

	// A stalled result item keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result item changed while stalled");

	// A sample item keeps the block busy for at least the following cycle.
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == tbcbe_pkg::CMD_SAMPLE) |=> !s_tready)
		else $error("input accepted right after a sample item");

	// A coefficient item never produces a result.
	a_coef_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == tbcbe_pkg::CMD_COEF) && !m_tvalid
		|=> !m_tvalid)
		else $error("result item after a coefficient item");

	// A new result never appears in the cycle right after an item is accepted.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result item appeared too early");

endmodule

bind three_band_crushing_bandpass_eq tbcbe_chk #(.OUT_TDW(OUT_TDW)) u_tbcbe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_three_band_crushing_bandpass_eq.sv =====
// Self-checking bench for the three-band crushing band-pass equalizer.
// Depends on tbcbe_pkg and the design; predicts every output sample in fixed point.
`timescale 1ns / 1ps

module tb_three_band_crushing_bandpass_eq;

	localparam int BANDS = tbcbe_pkg::BAND_COUNT_DEF;
	localparam int SLOTS = tbcbe_pkg::COEF_SLOTS;
	localparam int DPB = tbcbe_pkg::DELAYS_PER_BAND;
	localparam int FR = tbcbe_pkg::FRAC;
	localparam int SWD = tbcbe_pkg::SAMPLE_WIDTH_DEF;
	localparam int WONE = tbcbe_pkg::WET_ONE;
	localparam longint D_MAX = (longint'(1) <<< 39) - 1;
	localparam longint D_MIN = -D_MAX - 1;
	localparam int SETTLE = 200;
	localparam int PRESS_PHASE = 1;

	typedef struct {
		logic        cmd;
		logic [23:0] smp;
		logic [1:0]  band;
		logic [3:0]  slot;
		logic [31:0] val;
	} eq_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	three_band_crushing_bandpass_eq dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	eq_item_t     pending_items[$];
	eq_item_t     on_bus;
	logic [23:0]  expected_samples[$];
	int           err_cnt = 0;
	int           send_idle = 0;
	int           recv_stall = 0;
	int           phase_no = 0;
	int           hold_cnt = 0;
	logic         held = 1'b0;

	// Predictor state.
	logic [31:0] coef_mem [BANDS*SLOTS];
	longint      delay_mem [BANDS*DPB];
	logic [15:0] wet_reg = 16'(WONE);
	logic [5:0]  crush_reg = '0;

	initial forever #6 clk = ~clk;

	function automatic longint floor_mul(longint a, longint b, int sh);
		logic signed [127:0] p;
		p = a * b;
		return longint'(p >>> sh);
	endfunction

	function automatic longint sat40(longint v);
		return v < D_MIN ? D_MIN : (v > D_MAX ? D_MAX : v);
	endfunction

	function automatic longint coef_s(int b, int s);
		return longint'($signed(coef_mem[b*SLOTS+s]));
	endfunction

	function automatic longint run_band(int b, longint x);
		longint lvl, alvl, u, ua, t, y, bias, n, scale, recip;
		int d;
		d = b * DPB;
		lvl = coef_s(b, tbcbe_pkg::SLOT_LEVEL);
		alvl = lvl < 0 ? -lvl : lvl;
		scale = longint'({32'b0, coef_mem[b*SLOTS+tbcbe_pkg::SLOT_SCALE]});
		recip = coef_s(b, tbcbe_pkg::SLOT_RECIP);
		u = sat40(floor_mul(x, alvl, SWD - 1));
		ua = floor_mul(u, coef_s(b, tbcbe_pkg::SLOT_A0), FR);
		t = sat40(ua + delay_mem[d]);
		delay_mem[d] = sat40(delay_mem[d+1] - floor_mul(t, coef_s(b, tbcbe_pkg::SLOT_B1), FR));
		delay_mem[d+1] = sat40(-ua - floor_mul(t, coef_s(b, tbcbe_pkg::SLOT_B2), FR));
		if (crush_reg[b]) begin
			y = floor_mul(t, scale, 15);
			bias = crush_reg[BANDS+b] ? (recip >>> 1) : 0;
			n = (y + bias) >>> FR;
			t = sat40(floor_mul(n, recip, 0));
		end
		ua = floor_mul(t, coef_s(b, tbcbe_pkg::SLOT_C0), FR);
		u = sat40(ua + delay_mem[d+2]);
		delay_mem[d+2] = sat40(delay_mem[d+3] - floor_mul(u, coef_s(b, tbcbe_pkg::SLOT_D1), FR));
		delay_mem[d+3] = sat40(-ua - floor_mul(u, coef_s(b, tbcbe_pkg::SLOT_D2), FR));
		return sat40(floor_mul(u, lvl, FR));
	endfunction

	function automatic logic [23:0] equalize(logic [23:0] smp);
		longint x, sum, w, dry, m, y;
		x = longint'($signed(smp));
		sum = 0;
		for (int b = 0; b < BANDS; b++)
			sum += run_band(b, x);
		w = wet_reg > WONE ? WONE : wet_reg;
		dry = x <<< (FR - SWD + 1);
		m = sat40((dry * (WONE - w) + sum * w) >>> 15);
		y = m >>> (FR - SWD + 1);
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		return y[23:0];
	endfunction

	function automatic void apply_item(eq_item_t it);
		if (it.cmd == tbcbe_pkg::CMD_COEF) begin
			if (it.band < BANDS && it.slot < SLOTS)
				coef_mem[it.band*SLOTS+it.slot] = it.val;
		end else begin
			expected_samples.push_back(equalize(it.smp));
		end
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	// Plausible filter values most of the time; occasionally any word at all.
	function automatic logic [31:0] pick_coef(int slot, bit wild);
		int v;
		if (wild && $urandom_range(7) == 0)
			return $urandom;
		case (slot)
			tbcbe_pkg::SLOT_A0, tbcbe_pkg::SLOT_C0:
				v = int'($urandom_range(1 << 28)) - (1 << 27);
			tbcbe_pkg::SLOT_B1, tbcbe_pkg::SLOT_D1:
				v = int'($urandom_range(966367640)) - 483183820;
			tbcbe_pkg::SLOT_B2, tbcbe_pkg::SLOT_D2:
				v = int'($urandom_range(241591910));
			tbcbe_pkg::SLOT_LEVEL:
				v = int'($urandom_range(1 << 30)) - (1 << 29);
			tbcbe_pkg::SLOT_SCALE:
				v = int'($urandom_range(1 << 22, 1 << 15));
			default:
				v = int'($urandom_range(1 << 28, 1 << 10));
		endcase
		return 32'(v);
	endfunction

	function automatic void add_coef(int band, int slot, logic [31:0] val);
		eq_item_t it;
		it.cmd = tbcbe_pkg::CMD_COEF;
		it.smp = 24'($urandom);
		it.band = 2'(band);
		it.slot = 4'(slot);
		it.val = val;
		pending_items.push_back(it);
	endfunction

	function automatic void add_sample(logic [23:0] smp);
		eq_item_t it;
		it.cmd = tbcbe_pkg::CMD_SAMPLE;
		it.smp = smp;
		it.band = 2'($urandom);
		it.slot = 4'($urandom);
		it.val = $urandom;
		pending_items.push_back(it);
	endfunction

	function automatic void add_random(int n);
		int slot;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				slot = ($urandom_range(4) == 0) ? int'($urandom_range(15)) :
					int'($urandom_range(8));
				add_coef(int'($urandom_range(3)), slot, pick_coef(slot, 1'b1));
			end else if ($urandom_range(9) == 0) begin
				add_sample($urandom_range(1) ? 24'h7fffff : 24'h800000);
			end else begin
				add_sample(24'($urandom));
			end
		end
	endfunction

	// Input driver: accepted items update the predictor, then the next one is offered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				apply_item(on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					on_bus = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_bus.cmd;
					s_tdata <= {2'b0, on_bus.val, on_bus.slot, on_bus.band, on_bus.smp};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random stalls plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (phase_no == PRESS_PHASE && !held) begin
				held <= 1'b1;
				hold_cnt <= 3000;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_samples.size() == 0)
				report_mismatch("unexpected sample_out", m_tdata, 24'h0);
			else if (m_tdata !== expected_samples[0])
				report_mismatch("sample_out", m_tdata, expected_samples.pop_front());
			else
				void'(expected_samples.pop_front());
		end
	end

	task automatic reg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == tbcbe_pkg::REG_WET_MIX)
			wet_reg = val[15:0];
		else
			crush_reg = val[5:0];
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [15:0] wets [8];
		logic [5:0]  crushes [8];
		wets = '{16'(WONE), 16'd0, 16'hffff, 16'd16384, 16'd1, 16'd32767, 16'd0, 16'd0};
		crushes = '{6'd0, 6'd63, 6'd7, 6'd56, 6'd5, 6'd0, 6'd63, 6'd0};
		wets[7] = 16'($urandom);
		crushes[7] = 6'($urandom);
		foreach (coef_mem[i]) coef_mem[i] = '0;
		foreach (delay_mem[i]) delay_mem[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 8; p++) begin
			reg_write(tbcbe_pkg::REG_WET_MIX, {$urandom_range(65535) == 0 ? 16'h0 : 16'h0,
				wets[p]});
			reg_write(tbcbe_pkg::REG_CRUSH_MODE, {26'b0, crushes[p]});
			phase_no = p;
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 50; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 50; end
				default: begin send_idle = 33; recv_stall = 33; end
			endcase
			if (p == 0) begin
				// Fill every coefficient before any sample, then ignored writes and extremes.
				for (int b = 0; b < BANDS; b++)
					for (int s = 0; s < SLOTS; s++)
						add_coef(b, s, pick_coef(s, 1'b0));
				add_coef(3, tbcbe_pkg::SLOT_A0, 32'hffffffff);
				add_coef(0, 9, 32'h80000000);
				add_coef(1, 15, 32'h7fffffff);
				add_sample(24'h000000);
				add_sample(24'h7fffff);
				add_sample(24'h800000);
				add_sample(24'hffffff);
				add_sample(24'h000001);
			end
			add_random(50);
			drain();
		end

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== three_band_crushing_bandpass_eq.f =====
design/tbcbe_pkg.sv
design/tbcbe_ram.sv
design/three_band_crushing_bandpass_eq.sv
design/tbcbe_chk.sv
bench/tb_three_band_crushing_bandpass_eq.sv
